### hdl/brpe_pkg.sv
package brpe_pkg;

   // Request opcodes.
   localparam logic OP_PUSH   = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_RUN_MIN = 1'b0;
   localparam logic CSR_RUN_MAX = 1'b1;

   localparam logic [3:0] RUN_MIN_RESET = 4'd3;
   localparam logic [7:0] RUN_MAX_RESET = 8'd130;

   // The shortest run length is clamped to this value.
   localparam logic [3:0] RUN_MIN_CAP = 4'd8;
   // A run is always cut at this length.
   localparam logic [7:0] LEN_CAP = 8'd255;

   // Literal header is count - LIT_MIN + LIT_BIAS, modulo 256.
   localparam int LIT_MIN  = 1;
   localparam int LIT_BIAS = 128;

   // Results beyond this count within one item are dropped.
   localparam logic [5:0] MAX_RESULTS = 6'd40;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_item;
      logic       block_end;
   } rsp_type;

   // Work for the back end, one entry per item that has any.
   // Order of execution: literal copies, then the literal flush, then the run.
   typedef struct packed {
      logic [2:0] lit_n;
      logic [7:0] lit_val;
      logic       run_en;
      logic [7:0] run_hdr;
      logic [7:0] run_val;
      logic       finish;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PUSH,
      BK_FL_HDR,
      BK_FL_DATA,
      BK_RUN_HDR,
      BK_RUN_VAL,
      BK_DONE
   } bk_state_type;

endpackage

### hdl/brpe_ram.sv
module brpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/brpe_front.sv
module brpe_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  brpe_pkg::req_type req_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output brpe_pkg::cmd_type cmd_data
);
   import brpe_pkg::*;

   logic [3:0] run_min_ff, run_min_in;
   logic [7:0] run_max_ff, run_max_in;
   logic [7:0] cur_value_ff, cur_value_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [7:0] cur_len_ff, cur_len_in;

   logic [3:0] eff_min;
   logic [7:0] len_inc;
   logic       same;
   logic       close_run;
   logic       close_lit;
   logic       accept;
   cmd_type    cmd;

   assign eff_min   = (run_min_ff > RUN_MIN_CAP) ? RUN_MIN_CAP : run_min_ff;
   assign len_inc   = cur_len_ff + 8'd1;
   assign same      = cur_valid_ff && (req_data.data_byte == cur_value_ff);
   assign close_run = cur_valid_ff && (cur_len_ff >= {4'd0, eff_min});
   assign close_lit = cur_valid_ff && !close_run;

   assign req_ready = cmd_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd          = '0;
      cur_value_in = cur_value_ff;
      cur_valid_in = cur_valid_ff;
      cur_len_in   = cur_len_ff;

      if (req_data.opcode == OP_PUSH && same) begin
         if (len_inc == run_max_ff || len_inc == LEN_CAP) begin
            cmd.run_en   = 1'b1;
            cmd.run_hdr  = len_inc - {4'd0, eff_min};
            cmd.run_val  = cur_value_ff;
            cur_value_in = 8'd0;
            cur_valid_in = 1'b0;
            cur_len_in   = 8'd0;
         end else begin
            cur_len_in = len_inc;
         end
      end else begin
         // Close the current run: as a run if long enough, else as literals.
         // A literal run is shorter than eff_min, so it fits in three bits.
         cmd.run_en  = close_run;
         cmd.run_hdr = cur_len_ff - {4'd0, eff_min};
         cmd.run_val = cur_value_ff;
         cmd.lit_n   = close_lit ? cur_len_ff[2:0] : 3'd0;
         cmd.lit_val = cur_value_ff;
         if (req_data.opcode == OP_PUSH) begin
            cur_value_in = req_data.data_byte;
            cur_valid_in = 1'b1;
            cur_len_in   = 8'd1;
         end else begin
            cmd.finish   = 1'b1;
            cur_value_in = 8'd0;
            cur_valid_in = 1'b0;
            cur_len_in   = 8'd0;
         end
      end

      run_min_in = run_min_ff;
      run_max_in = run_max_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RUN_MIN: run_min_in = csr_wdata[3:0];
            CSR_RUN_MAX: run_max_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign cmd_valid = req_valid && (cmd.run_en || (cmd.lit_n != 3'd0) || cmd.finish);
   assign cmd_data  = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_min_ff   <= RUN_MIN_RESET;
         run_max_ff   <= RUN_MAX_RESET;
         cur_value_ff <= 8'd0;
         cur_valid_ff <= 1'b0;
         cur_len_ff   <= 8'd0;
      end else begin
         run_min_ff <= run_min_in;
         run_max_ff <= run_max_in;
         if (accept) begin
            cur_value_ff <= cur_value_in;
            cur_valid_ff <= cur_valid_in;
            cur_len_ff   <= cur_len_in;
         end
      end
   end

endmodule

### hdl/brpe_cmd_fifo.sv
module brpe_cmd_fifo #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  brpe_pkg::cmd_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output brpe_pkg::cmd_type out_data
);
   import brpe_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   cmd_type        mem_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]  count_ff, count_in;
   logic           push;
   logic           pop;

   assign in_ready  = (count_ff != NW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

### hdl/brpe_back.sv
module brpe_back #(
   parameter int LIT_MAX = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  brpe_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output brpe_pkg::rsp_type rsp_data
);
   import brpe_pkg::*;

   localparam int AW = (LIT_MAX > 1) ? $clog2(LIT_MAX) : 1;
   localparam int CW = $clog2(LIT_MAX + 1);

   bk_state_type  state_ff, state_in;
   logic [2:0]    lit_left_ff, lit_left_in;
   logic [7:0]    lit_val_ff, lit_val_in;
   logic          run_pend_ff, run_pend_in;
   logic [7:0]    run_hdr_ff, run_hdr_in;
   logic [7:0]    run_val_ff, run_val_in;
   logic          fin_ff, fin_in;
   logic [CW-1:0] lit_cnt_ff, lit_cnt_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [5:0]    emit_cnt_ff, emit_cnt_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [7:0]    pend_byte_ff, pend_byte_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic          ram_we;
   logic [7:0]    ram_wdata;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   logic          out_free;
   logic          drop;
   logic          emit_go;
   logic          emit_pend;
   logic          emit_req;
   logic [7:0]    emit_byte;
   logic          out_load;
   rsp_type       out_item;
   logic [CW-1:0] cnt_inc;
   logic [CW-1:0] rd_inc;
   logic          full;

   // Picks the next step of the current item from what is still to be done.
   function automatic bk_state_type dispatch(logic [2:0] left, logic run_p, logic fin,
                                             logic cnt_nz, logic pend);
      bk_state_type nxt;
      if (left != 3'd0) begin
         nxt = BK_PUSH;
      end else if ((run_p || fin) && cnt_nz) begin
         nxt = BK_FL_HDR;
      end else if (run_p) begin
         nxt = BK_RUN_HDR;
      end else if (pend) begin
         nxt = BK_DONE;
      end else begin
         nxt = BK_IDLE;
      end
      return nxt;
   endfunction

   brpe_ram #(
      .WIDTH (8),
      .DEPTH (LIT_MAX)
   ) u_lit_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (lit_cnt_ff[AW-1:0]),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign drop      = (emit_cnt_ff >= MAX_RESULTS);
   assign emit_go   = drop || !pend_valid_ff || out_free;
   assign emit_pend = drop ? pend_valid_ff : 1'b1;
   assign cnt_inc   = lit_cnt_ff + CW'(1);
   assign rd_inc    = rd_idx_ff + CW'(1);
   assign full      = (cnt_inc == CW'(LIT_MAX));

   always_comb begin
      state_in      = state_ff;
      lit_left_in   = lit_left_ff;
      lit_val_in    = lit_val_ff;
      run_pend_in   = run_pend_ff;
      run_hdr_in    = run_hdr_ff;
      run_val_in    = run_val_ff;
      fin_in        = fin_ff;
      lit_cnt_in    = lit_cnt_ff;
      rd_idx_in     = rd_idx_ff;
      emit_cnt_in   = emit_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      cmd_ready     = 1'b0;
      ram_we        = 1'b0;
      ram_wdata     = lit_val_ff;
      ram_re        = 1'b0;
      ram_raddr     = '0;
      emit_req      = 1'b0;
      emit_byte     = 8'd0;
      out_load      = 1'b0;
      out_item      = '0;

      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_ready   = 1'b1;
               lit_val_in  = cmd_data.lit_val;
               run_pend_in = cmd_data.run_en;
               run_hdr_in  = cmd_data.run_hdr;
               run_val_in  = cmd_data.run_val;
               fin_in      = cmd_data.finish;
               emit_cnt_in = 6'd0;
               if (cmd_data.lit_n != 3'd0) begin
                  // The first literal copy is stored right away.
                  ram_we      = 1'b1;
                  ram_wdata   = cmd_data.lit_val;
                  lit_left_in = cmd_data.lit_n - 3'd1;
                  lit_cnt_in  = cnt_inc;
                  state_in    = full ? BK_FL_HDR :
                                dispatch(cmd_data.lit_n - 3'd1, cmd_data.run_en,
                                         cmd_data.finish, 1'b1, pend_valid_ff);
               end else begin
                  lit_left_in = 3'd0;
                  state_in    = dispatch(3'd0, cmd_data.run_en, cmd_data.finish,
                                         lit_cnt_ff != '0, pend_valid_ff);
               end
            end
         end
         BK_PUSH: begin
            ram_we      = 1'b1;
            lit_left_in = lit_left_ff - 3'd1;
            lit_cnt_in  = cnt_inc;
            state_in    = full ? BK_FL_HDR :
                          dispatch(lit_left_ff - 3'd1, run_pend_ff, fin_ff, 1'b1,
                                   pend_valid_ff);
         end
         BK_FL_HDR: begin
            emit_req  = 1'b1;
            emit_byte = 8'(lit_cnt_ff) + 8'(LIT_BIAS - LIT_MIN);
            if (emit_go) begin
               ram_re    = 1'b1;
               ram_raddr = '0;
               rd_idx_in = '0;
               state_in  = BK_FL_DATA;
            end
         end
         BK_FL_DATA: begin
            emit_req  = 1'b1;
            emit_byte = ram_rdata;
            if (emit_go) begin
               if (rd_inc < lit_cnt_ff) begin
                  ram_re    = 1'b1;
                  ram_raddr = rd_inc[AW-1:0];
                  rd_idx_in = rd_inc;
               end else begin
                  lit_cnt_in = '0;
                  state_in   = dispatch(lit_left_ff, run_pend_ff, fin_ff, 1'b0, emit_pend);
               end
            end
         end
         BK_RUN_HDR: begin
            emit_req  = 1'b1;
            emit_byte = run_hdr_ff;
            if (emit_go) begin
               state_in = BK_RUN_VAL;
            end
         end
         BK_RUN_VAL: begin
            emit_req  = 1'b1;
            emit_byte = run_val_ff;
            if (emit_go) begin
               run_pend_in = 1'b0;
               state_in    = dispatch(lit_left_ff, 1'b0, fin_ff, lit_cnt_ff != '0, emit_pend);
            end
         end
         BK_DONE: begin
            // The held byte is the final result of the item.
            if (out_free) begin
               out_load              = 1'b1;
               out_item.out_byte     = pend_byte_ff;
               out_item.last_of_item = 1'b1;
               out_item.block_end    = fin_ff;
               pend_valid_in         = 1'b0;
               state_in              = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      // A new byte goes to the hold register; the byte it displaces is not
      // the final one of the item and moves on to the output register.
      if (emit_req && emit_go && !drop) begin
         emit_cnt_in   = emit_cnt_ff + 6'd1;
         pend_valid_in = 1'b1;
         pend_byte_in  = emit_byte;
         if (pend_valid_ff) begin
            out_load          = 1'b1;
            out_item.out_byte = pend_byte_ff;
         end
      end

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = out_load ? out_item : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         lit_left_ff   <= 3'd0;
         run_pend_ff   <= 1'b0;
         fin_ff        <= 1'b0;
         lit_cnt_ff    <= '0;
         rd_idx_ff     <= '0;
         emit_cnt_ff   <= 6'd0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lit_left_ff   <= lit_left_in;
         run_pend_ff   <= run_pend_in;
         fin_ff        <= fin_in;
         lit_cnt_ff    <= lit_cnt_in;
         rd_idx_ff     <= rd_idx_in;
         emit_cnt_ff   <= emit_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lit_val_ff   <= lit_val_in;
      run_hdr_ff   <= run_hdr_in;
      run_val_ff   <= run_val_in;
      pend_byte_ff <= pend_byte_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hdl/byte_rle_packbits_encoder.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  brpe_pkg::req_type (opcode, data_byte)
// rsp_      out        rsp_valid/rsp_ready  brpe_pkg::rsp_type (out_byte, last_of_item,
//                                           block_end)
// csr_      in         csr_we               csr_index, csr_wdata (run_min, run_max)
//
// The front end takes one item per cycle while the command queue has room. The back end
// picks up a command, which also stores its first literal copy, then stores one copy or sends
// one compressed byte per cycle while not stalled, and ends an item with results by sending
// its held final byte. A flush sends a header, then the literals. Reset is synchronous and
// clears the run state, queue and output; the literal store needs no clearing. A stalled
// output holds the back end; the queue keeps the front end accepting until it fills.
module byte_rle_packbits_encoder #(
   parameter int LIT_MAX     = 32,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  brpe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output brpe_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata
);
   import brpe_pkg::*;

   // Commands from the run tracker to the queue.
   logic    fe_cmd_valid;
   logic    fe_cmd_ready;
   cmd_type fe_cmd;

   // Commands from the queue to the literal store and byte sequencer.
   logic    bk_cmd_valid;
   logic    bk_cmd_ready;
   cmd_type bk_cmd;

   // The front end follows the current run and decides, per item, what the
   // back end has to do: store literal copies, send a run, or close the block.
   brpe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (fe_cmd_valid),
      .cmd_ready (fe_cmd_ready),
      .cmd_data  (fe_cmd)
   );

   brpe_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_cmd_valid),
      .in_ready  (fe_cmd_ready),
      .in_data   (fe_cmd),
      .out_valid (bk_cmd_valid),
      .out_ready (bk_cmd_ready),
      .out_data  (bk_cmd)
   );

   // The back end owns the literal store and emits the compressed bytes. The
   // final byte of each item is held back in a hold register so that it can be marked.
   brpe_back #(
      .LIT_MAX (LIT_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (bk_cmd_valid),
      .cmd_ready (bk_cmd_ready),
      .cmd_data  (bk_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // The end of a block is always the final byte of its item.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.block_end |-> rsp_data.last_of_item)
      else $error("block_end without last_of_item");

   // No result survives a reset.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The front end only stalls when the queue holds work for the back end.
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> bk_cmd_valid)
      else $error("request stalled with an empty command queue");
`endif

endmodule

### bench/brpe_output_checker.sv
module brpe_output_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  brpe_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  brpe_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata,
   output int                fail_count,
   output int                pending
);
   import brpe_pkg::*;

   localparam int LIT_MAX = 32;

   logic [3:0] run_min_q;
   logic [7:0] run_max_q;
   logic [7:0] run_value;
   bit         run_open;
   int         run_len;
   logic [7:0] lit_buf [LIT_MAX];
   int         lit_count;
   int         item_results;
   int         mismatches;
   rsp_type    expected_bytes [$];

   function automatic int shortest_run();
      return (run_min_q > RUN_MIN_CAP) ? int'(RUN_MIN_CAP) : int'(run_min_q);
   endfunction

   task automatic put_byte(input logic [7:0] b);
      rsp_type r;
      if (item_results < int'(MAX_RESULTS)) begin
         r.out_byte     = b;
         r.last_of_item = 1'b0;
         r.block_end    = 1'b0;
         expected_bytes.push_back(r);
         item_results++;
      end
   endtask

   task automatic flush_literals();
      if (lit_count != 0) begin
         put_byte(8'(lit_count - LIT_MIN + LIT_BIAS));
         for (int i = 0; i < lit_count; i++) begin
            put_byte(lit_buf[i]);
         end
         lit_count = 0;
      end
   endtask

   task automatic emit_run();
      flush_literals();
      put_byte(8'(run_len - shortest_run()));
      put_byte(run_value);
   endtask

   // A run long enough goes out as a run; a shorter one turns into literal copies.
   task automatic close_run();
      if (run_open) begin
         if (run_len >= shortest_run()) begin
            emit_run();
         end else begin
            for (int i = 0; i < run_len; i++) begin
               if (lit_count < LIT_MAX) begin
                  lit_buf[lit_count] = run_value;
                  lit_count++;
               end
               if (lit_count >= LIT_MAX) begin
                  flush_literals();
               end
            end
         end
      end
   endtask

   task automatic encode_item(input req_type it);
      int      first;
      rsp_type r;
      first        = expected_bytes.size();
      item_results = 0;
      if (it.opcode == OP_PUSH) begin
         if (run_open && it.data_byte == run_value) begin
            run_len++;
            if (run_len == int'(run_max_q) || run_len >= int'(LEN_CAP)) begin
               emit_run();
               run_open  = 1'b0;
               run_len   = 0;
               run_value = 8'h00;
            end
         end else begin
            close_run();
            run_value = it.data_byte;
            run_open  = 1'b1;
            run_len   = 1;
         end
      end else begin
         close_run();
         flush_literals();
         run_value = 8'h00;
         run_open  = 1'b0;
         run_len   = 0;
         lit_count = 0;
         if (expected_bytes.size() > first) begin
            r = expected_bytes.pop_back();
            r.block_end = 1'b1;
            expected_bytes.push_back(r);
         end
      end
      if (expected_bytes.size() > first) begin
         r = expected_bytes.pop_back();
         r.last_of_item = 1'b1;
         expected_bytes.push_back(r);
      end
   endtask

   task automatic note_failure(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         run_min_q = RUN_MIN_RESET;
         run_max_q = RUN_MAX_RESET;
         run_value = 8'h00;
         run_open  = 1'b0;
         run_len   = 0;
         lit_count = 0;
         mismatches = 0;
         expected_bytes.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_RUN_MIN) begin
               run_min_q = csr_wdata[3:0];
            end else begin
               run_max_q = csr_wdata;
            end
         end
         if (req_valid && req_ready) begin
            encode_item(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               note_failure($sformatf("unexpected item: byte %02h last %0b end %0b",
                  rsp_data.out_byte, rsp_data.last_of_item, rsp_data.block_end));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data.out_byte !== want.out_byte ||
                   rsp_data.last_of_item !== want.last_of_item ||
                   rsp_data.block_end !== want.block_end) begin
                  note_failure($sformatf(
                     "mismatch: expected byte %02h last %0b end %0b, got %02h %0b %0b",
                     want.out_byte, want.last_of_item, want.block_end,
                     rsp_data.out_byte, rsp_data.last_of_item, rsp_data.block_end));
               end
            end
         end
      end
      fail_count <= mismatches;
      pending    <= expected_bytes.size();
   end

endmodule

### bench/tb_byte_rle_packbits_encoder.sv
module tb_byte_rle_packbits_encoder;
   import brpe_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_we;
   logic    csr_index;
   logic [7:0] csr_wdata;
   int      fail_count;
   int      pending;

   // When set, neither side inserts idle cycles; used for the final phase.
   bit      calm;

   byte_rle_packbits_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // The checker watches both channels and the register port, predicts the
   // compressed stream and counts every mismatch it sees.
   brpe_output_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // A hard stop in case the block hangs; far beyond the slowest correct run.
   initial begin
      #20000000;
      $display("CHECK FAILED");
      $finish;
   end

   // The receiver is ready for a random stretch, then sometimes stalls for a
   // random burst. At most one assignment happens per clock edge.
   initial begin
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
         if (!calm && $urandom_range(0, 1) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
      end
   end

   // Presents one item and holds it until the block takes it. An optional
   // gap before the item drops valid for a burst of cycles. The task returns
   // right after the accepting edge, so the next call may keep valid high.
   task automatic send_item(input req_type it);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b);
      req_type it;
      it.opcode    = OP_PUSH;
      it.data_byte = b;
      send_item(it);
   endtask

   // The data byte of a finish is ignored, so it carries random content.
   task automatic send_finish();
      req_type it;
      it.opcode    = OP_FINISH;
      it.data_byte = 8'($urandom_range(0, 255));
      send_item(it);
   endtask

   task automatic send_run(input logic [7:0] b, input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(b);
      end
   endtask

   // Waits until every predicted result has come out. Items that produce no
   // result may still sit in the block, so a fixed drain follows.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_limits(input logic [7:0] min_len, input logic [7:0] max_len);
      csr_we    <= 1'b1;
      csr_index <= CSR_RUN_MIN;
      csr_wdata <= min_len;
      @(posedge clock);
      csr_index <= CSR_RUN_MAX;
      csr_wdata <= max_len;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // One phase of random traffic: mostly runs of random length and literal
   // strings, sometimes a burst of differing bytes that may fill the literal
   // store, a finish, or an item with a random opcode.
   task automatic random_phase(input int budget);
      int         sent;
      int         kind;
      int         len;
      logic [7:0] b;
      req_type    it;
      sent = 0;
      while (sent < budget) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            send_finish();
            sent++;
         end else if (kind <= 4) begin
            len = $urandom_range(1, 10);
            b   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 1) * 255)
                                              : 8'($urandom_range(0, 255));
            send_run(b, len);
            sent += len;
         end else if (kind <= 7) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               send_byte(8'($urandom_range(0, 255)));
            end
            sent += len;
         end else if (kind == 8) begin
            // Neighbors always differ, so no run forms within the burst.
            len = $urandom_range(30, 36);
            b   = 8'($urandom_range(0, 255));
            for (int i = 0; i < len; i++) begin
               send_byte(b);
               b = b + 8'($urandom_range(1, 255));
            end
            sent += len;
         end else begin
            it.opcode    = 1'($urandom_range(0, 1));
            it.data_byte = 8'($urandom_range(0, 255));
            send_item(it);
            sent++;
         end
      end
      send_finish();
   endtask

   initial begin
      // Register settings per phase: the low extremes, the clamp limit itself,
      // a shortest run of zero with no cut length, a shortest run above the
      // clamp with a cut below it, a shortest run of one with a cut at two,
      // and finally the reset values.
      logic [7:0] min_tab [6];
      logic [7:0] max_tab [6];
      min_tab = '{8'd2, 8'd8, 8'd0, 8'd15, 8'd1, 8'd3};
      max_tab = '{8'd3, 8'd130, 8'd0, 8'd5, 8'd2, 8'd130};

      calm      = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_RUN_MIN;
      csr_wdata <= 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings. An empty block gives no
      // result at all. Then a single literal, a repeat too short for a run,
      // a run of exactly the shortest length that forces the pending
      // literals out first, a longer run closed by the next byte, and a finish.
      send_finish();
      send_byte(8'h00);
      send_finish();
      send_run(8'hFF, 2);
      send_run(8'h00, 3);
      send_run(8'h7F, 4);
      send_byte(8'h80);
      send_finish();

      for (int p = 0; p < 6; p++) begin
         wait_drained();
         write_limits(min_tab[p], max_tab[p]);
         // The last phase runs without any idle cycles on either side.
         if (p == 5) begin
            calm = 1'b1;
         end
         random_phase(12);
      end

      wait_drained();
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
